/* src/gsbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gsbm_pkg;

   // Default geometry of one image block and of the template set
   localparam int BLOCK_WIDTH_DEF  = 4;
   localparam int BLOCK_HEIGHT_DEF = 8;
   localparam int GLYPH_COUNT_DEF  = 94;

   // Field widths of the request and response beats
   localparam int SLOT_FIELD_W  = 7;
   localparam int POS_FIELD_W   = 5;
   localparam int COLOR_W       = 8;
   localparam int LEVEL_W       = 8;
   localparam int CODE_W        = 7;
   localparam int DISTANCE_W    = 13;

   // Q0.16 luma weights, summing to 65536
   localparam int WEIGHT_W      = 16;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd13933;
   localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd46871;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd4732;
   localparam int GRAY_ACC_W    = COLOR_W + WEIGHT_W;

   localparam int CODE_BASE     = 33;
   localparam logic [DISTANCE_W-1:0] DISTANCE_MAX = 13'd8191;

   // Request command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // Color channel steps of the gray converter
   localparam logic [1:0] STEP_RED   = 2'd0;
   localparam logic [1:0] STEP_GREEN = 2'd1;
   localparam logic [1:0] STEP_BLUE  = 2'd2;

   // Control that travels with each template read during the scan
   typedef struct packed {
      logic valid;
      logic glyph_end;
      logic last_glyph;
   } scan_ctrl_type;

   function automatic logic [WEIGHT_W-1:0] color_weight(input logic [1:0] step);
      logic [WEIGHT_W-1:0] w;
      unique case (step)
         STEP_RED:   w = WEIGHT_RED;
         STEP_GREEN: w = WEIGHT_GREEN;
         STEP_BLUE:  w = WEIGHT_BLUE;
         default:    w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* src/glyph_sad_best_match.sv */
// Best-matching glyph finder. Load beats (command 0) write one template gray
// level each and leave the block ready for the next beat. Pixel beats
// (command 1) are converted to gray by one shared multiply-accumulate, red,
// then green, then blue, and written to the block buffer.
// The last pixel of a block then starts a scan that reads the template memory
// one level per cycle through a single read port, summing absolute differences
// in one shared unit, then drains the pipeline and loads the response. Requests
// stall while a pixel converts and through scan, drain and response load.
// The response register frees the block for template loads while a result
// waits; a new scan result waits in turn for the previous response to leave.
// Out-of-range loads and pixels are accepted and dropped. Ties go to the
// lowest glyph slot; the character code is 33 plus that slot.
`timescale 1ns / 1ps
`default_nettype none

module glyph_sad_best_match #(
   parameter int BLOCK_WIDTH  = gsbm_pkg::BLOCK_WIDTH_DEF,
   parameter int BLOCK_HEIGHT = gsbm_pkg::BLOCK_HEIGHT_DEF,
   parameter int GLYPH_COUNT  = gsbm_pkg::GLYPH_COUNT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_command,
   input  wire logic [gsbm_pkg::SLOT_FIELD_W-1:0]   req_glyph_slot,
   input  wire logic [gsbm_pkg::POS_FIELD_W-1:0]    req_pixel_position,
   input  wire logic [gsbm_pkg::COLOR_W-1:0]        req_red,
   input  wire logic [gsbm_pkg::COLOR_W-1:0]        req_green,
   input  wire logic [gsbm_pkg::COLOR_W-1:0]        req_blue,
   input  wire logic [gsbm_pkg::LEVEL_W-1:0]        req_template_level,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [gsbm_pkg::CODE_W-1:0]         rsp_character_code,
   output logic      [gsbm_pkg::DISTANCE_W-1:0]     rsp_best_distance
);

   localparam int PIXELS  = BLOCK_WIDTH * BLOCK_HEIGHT;
   localparam int TDEPTH  = GLYPH_COUNT * PIXELS;
   localparam int PIX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int SLOT_W  = $clog2(GLYPH_COUNT);
   localparam int TADDR_W = $clog2(TDEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                         state_ff, state_in;
   logic [PIX_W-1:0]                  pos_ff, pos_in;
   logic [PIX_W-1:0]                  pix_ff, pix_in;
   logic [SLOT_W-1:0]                 glyph_ff, glyph_in;
   logic [TADDR_W-1:0]                taddr_ff, taddr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gsbm_pkg::CODE_W-1:0]       rsp_code_ff, rsp_code_in;
   logic [gsbm_pkg::DISTANCE_W-1:0]   rsp_dist_ff, rsp_dist_in;

   logic                              req_fire;
   logic                              pos_ok;
   logic                              slot_ok;
   logic                              load_en;
   logic                              pixel_start;
   logic [TADDR_W-1:0]                load_addr;
   logic                              gray_done;
   logic [gsbm_pkg::LEVEL_W-1:0]      gray_level;
   logic [gsbm_pkg::LEVEL_W-1:0]      tmpl_level;
   logic [gsbm_pkg::LEVEL_W-1:0]      pix_level;
   gsbm_pkg::scan_ctrl_type           scan_ctrl;
   logic [SLOT_W-1:0]                 best_slot;
   logic [gsbm_pkg::DISTANCE_W-1:0]   best_distance;
   logic                              sad_done;
   logic                              last_pix;
   logic                              last_glyph;

   // Decode the request beat
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_fire    = req_valid & ~req_stall;
   assign pos_ok      = 32'(req_pixel_position) < PIXELS;
   assign slot_ok     = 32'(req_glyph_slot) < GLYPH_COUNT;
   assign load_en     = req_fire & (req_command == gsbm_pkg::CMD_LOAD) & pos_ok & slot_ok;
   assign pixel_start = req_fire & (req_command == gsbm_pkg::CMD_PIXEL) & pos_ok;
   assign load_addr   = TADDR_W'(32'(req_glyph_slot) * PIXELS + 32'(req_pixel_position));

   // Scan position flags
   assign last_pix   = (pix_ff == PIX_W'(PIXELS - 1));
   assign last_glyph = (glyph_ff == SLOT_W'(GLYPH_COUNT - 1));

   always_comb begin
      scan_ctrl.valid      = (state_ff == ST_SCAN);
      scan_ctrl.glyph_end  = last_pix;
      scan_ctrl.last_glyph = last_glyph;
   end

   gsbm_ram #(
      .WIDTH (gsbm_pkg::LEVEL_W),
      .DEPTH (TDEPTH)
   ) u_template_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_template_level),
      .rd_addr (taddr_ff),
      .rd_data (tmpl_level)
   );

   gsbm_ram #(
      .WIDTH (gsbm_pkg::LEVEL_W),
      .DEPTH (PIXELS)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (gray_done),
      .wr_addr (pos_ff),
      .wr_data (gray_level),
      .rd_addr (pix_ff),
      .rd_data (pix_level)
   );

   gsbm_gray u_gray (
      .clock (clock),
      .reset (reset),
      .start (pixel_start),
      .red   (req_red),
      .green (req_green),
      .blue  (req_blue),
      .done  (gray_done),
      .gray  (gray_level)
   );

   gsbm_sad #(
      .PIXELS      (PIXELS),
      .GLYPH_COUNT (GLYPH_COUNT),
      .SLOT_W      (SLOT_W)
   ) u_sad (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (scan_ctrl),
      .tmpl_level    (tmpl_level),
      .pix_level     (pix_level),
      .best_slot     (best_slot),
      .best_distance (best_distance),
      .done          (sad_done)
   );

   // Sequence convert, scan, drain and response load
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      pix_in       = pix_ff;
      glyph_in     = glyph_ff;
      taddr_in     = taddr_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_dist_in  = rsp_dist_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pixel_start) begin
               pos_in   = PIX_W'(req_pixel_position);
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            pix_in   = '0;
            glyph_in = '0;
            taddr_in = '0;
            if (gray_done) begin
               state_in = (pos_ff == PIX_W'(PIXELS - 1)) ? ST_SCAN : ST_IDLE;
            end
         end
         ST_SCAN: begin
            taddr_in = taddr_ff + TADDR_W'(1);
            pix_in   = pix_ff + PIX_W'(1);
            if (last_pix) begin
               pix_in   = '0;
               glyph_in = glyph_ff + SLOT_W'(1);
               if (last_glyph) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (sad_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = gsbm_pkg::CODE_W'(32'(best_slot) + gsbm_pkg::CODE_BASE);
               rsp_dist_in  = best_distance;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      pix_ff      <= pix_in;
      glyph_ff    <= glyph_in;
      taddr_ff    <= taddr_in;
      rsp_code_ff <= rsp_code_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_character_code = rsp_code_ff;
   assign rsp_best_distance  = rsp_dist_ff;

`ifndef SYNTHESIS
   a_gray_in_convert: assert property (@(posedge clock) disable iff (reset)
      gray_done |-> state_ff == ST_CONVERT)
      else $error("gray result outside pixel conversion");

   a_sad_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      sad_done |-> state_ff == ST_DRAIN)
      else $error("scan finished outside drain");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response loaded outside finish");

   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |->
         taddr_ff == TADDR_W'(32'(glyph_ff) * PIXELS + 32'(pix_ff)))
      else $error("template address out of step with scan counters");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |=> !load_en && !pixel_start)
      else $error("request accepted during scan");
`endif

endmodule

`default_nettype wire

/* src/gsbm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module gsbm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* src/gsbm_gray.sv */
`timescale 1ns / 1ps
`default_nettype none

module gsbm_gray (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [gsbm_pkg::COLOR_W-1:0]      red,
   input  wire logic [gsbm_pkg::COLOR_W-1:0]      green,
   input  wire logic [gsbm_pkg::COLOR_W-1:0]      blue,
   output logic                                   done,
   output logic      [gsbm_pkg::LEVEL_W-1:0]      gray
);

   localparam int ACC_W = gsbm_pkg::GRAY_ACC_W;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [1:0]                        step_ff, step_in;
   logic [ACC_W-1:0]                  acc_ff, acc_in;
   logic [gsbm_pkg::COLOR_W-1:0]      color_ff [3];
   logic [gsbm_pkg::COLOR_W-1:0]      operand;

   // One multiply-accumulate per cycle, one color channel per step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      operand = color_ff[step_ff];
      if (start) begin
         busy_in = 1'b1;
         step_in = gsbm_pkg::STEP_RED;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = acc_ff + ACC_W'(operand * gsbm_pkg::color_weight(step_ff));
         step_in = step_ff + 2'd1;
         if (step_ff == gsbm_pkg::STEP_BLUE) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= gsbm_pkg::STEP_RED;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      if (start) begin
         color_ff[0] <= red;
         color_ff[1] <= green;
         color_ff[2] <= blue;
      end
   end

   // Truncate the Q8.16 weighted sum to the integer gray level
   assign done = done_ff;
   assign gray = acc_ff[ACC_W-1 -: gsbm_pkg::LEVEL_W];

endmodule

`default_nettype wire

/* src/gsbm_sad.sv */
`timescale 1ns / 1ps
`default_nettype none

module gsbm_sad #(
   parameter int PIXELS      = gsbm_pkg::BLOCK_WIDTH_DEF * gsbm_pkg::BLOCK_HEIGHT_DEF,
   parameter int GLYPH_COUNT = gsbm_pkg::GLYPH_COUNT_DEF,
   parameter int SLOT_W      = $clog2(GLYPH_COUNT)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire gsbm_pkg::scan_ctrl_type           ctrl,
   input  wire logic [gsbm_pkg::LEVEL_W-1:0]      tmpl_level,
   input  wire logic [gsbm_pkg::LEVEL_W-1:0]      pix_level,
   output logic      [SLOT_W-1:0]                 best_slot,
   output logic      [gsbm_pkg::DISTANCE_W-1:0]   best_distance,
   output logic                                   done
);

   localparam int SUM_W = $clog2(255 * PIXELS + 1);

   gsbm_pkg::scan_ctrl_type           ctrl_ff;
   logic [SUM_W-1:0]                  acc_ff, acc_in;
   logic [SUM_W-1:0]                  glyph_sum_ff, glyph_sum_in;
   logic [SLOT_W-1:0]                 cur_slot_ff, cur_slot_in;
   logic                              cmp_valid_ff, cmp_valid_in;
   logic                              cmp_last_ff, cmp_last_in;
   logic [SLOT_W-1:0]                 cmp_slot_ff, cmp_slot_in;
   logic [SLOT_W-1:0]                 best_slot_ff, best_slot_in;
   logic [SUM_W-1:0]                  best_sum_ff, best_sum_in;
   logic                              done_ff, done_in;
   logic [gsbm_pkg::LEVEL_W-1:0]      diff;
   logic [SUM_W-1:0]                  sum_next;

   // Accumulate one absolute difference per beat of template data
   always_comb begin
      diff         = (tmpl_level > pix_level) ? (tmpl_level - pix_level)
                                              : (pix_level - tmpl_level);
      sum_next     = acc_ff + SUM_W'(diff);
      acc_in       = acc_ff;
      glyph_sum_in = glyph_sum_ff;
      cur_slot_in  = cur_slot_ff;
      cmp_valid_in = 1'b0;
      cmp_last_in  = 1'b0;
      cmp_slot_in  = cmp_slot_ff;
      if (ctrl_ff.valid) begin
         acc_in = sum_next;
         if (ctrl_ff.glyph_end) begin
            acc_in       = '0;
            glyph_sum_in = sum_next;
            cmp_valid_in = 1'b1;
            cmp_last_in  = ctrl_ff.last_glyph;
            cmp_slot_in  = cur_slot_ff;
            cur_slot_in  = ctrl_ff.last_glyph ? '0 : cur_slot_ff + SLOT_W'(1);
         end
      end
   end

   // Keep the first glyph with the smallest sum
   always_comb begin
      best_slot_in = best_slot_ff;
      best_sum_in  = best_sum_ff;
      done_in      = cmp_valid_ff & cmp_last_ff;
      if (cmp_valid_ff) begin
         if (cmp_slot_ff == '0 || glyph_sum_ff < best_sum_ff) begin
            best_slot_in = cmp_slot_ff;
            best_sum_in  = glyph_sum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         acc_ff       <= '0;
         cur_slot_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         cmp_last_ff  <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         ctrl_ff      <= ctrl;
         acc_ff       <= acc_in;
         cur_slot_ff  <= cur_slot_in;
         cmp_valid_ff <= cmp_valid_in;
         cmp_last_ff  <= cmp_last_in;
         done_ff      <= done_in;
      end
      glyph_sum_ff <= glyph_sum_in;
      cmp_slot_ff  <= cmp_slot_in;
      best_slot_ff <= best_slot_in;
      best_sum_ff  <= best_sum_in;
   end

   // Saturate the distance to the response field
   always_comb begin
      if (32'(best_sum_ff) > 32'(gsbm_pkg::DISTANCE_MAX)) begin
         best_distance = gsbm_pkg::DISTANCE_MAX;
      end else begin
         best_distance = gsbm_pkg::DISTANCE_W'(best_sum_ff);
      end
   end

   assign best_slot = best_slot_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

/* bench/glyph_sad_best_match_tb.sv */
`timescale 1ns / 1ps

module glyph_sad_best_match_tb;

   localparam int          BLOCK_PIXELS   = 32;
   localparam int          GLYPHS         = 94;
   localparam int unsigned LUMA_R         = 13933;
   localparam int unsigned LUMA_G         = 46871;
   localparam int unsigned LUMA_B         = 4732;
   localparam int unsigned CHAR_BASE      = 33;
   localparam int unsigned DIST_CEIL      = 8191;
   localparam int          ITEMS_TARGET   = 1350;
   localparam int          DRAIN_CYCLES   = 3100;
   // Room for every beat to start a full scan behind the longest stalls, several times over
   localparam int          CYCLE_LIMIT    = 100000000;
   localparam int          SCRIPT_ROWS    = 22;

   localparam logic LOAD  = gsbm_pkg::CMD_LOAD;
   localparam logic PIXEL = gsbm_pkg::CMD_PIXEL;

   typedef struct packed {
      logic       command;
      logic [6:0] slot;
      logic [4:0] pos;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] level;
   } glyph_req_type;

   typedef struct packed {
      logic [6:0]  code;
      logic [12:0] distance;
   } glyph_match_type;

   typedef struct packed {
      logic        cmd;
      logic [6:0]  slot;
      logic [4:0]  pos;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  level;
      logic        typed;
      logic [6:0]  want_code;
      logic [12:0] want_dist;
   } script_row_type;

   typedef enum int {FILL_RANDOM, FILL_UNIFORM, FILL_REPLICA, FILL_NEAR} block_fill_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = 1'b0;
   logic [gsbm_pkg::SLOT_FIELD_W-1:0] req_glyph_slot = '0;
   logic [gsbm_pkg::POS_FIELD_W-1:0]  req_pixel_position = '0;
   logic [gsbm_pkg::COLOR_W-1:0]      req_red = '0;
   logic [gsbm_pkg::COLOR_W-1:0]      req_green = '0;
   logic [gsbm_pkg::COLOR_W-1:0]      req_blue = '0;
   logic [gsbm_pkg::LEVEL_W-1:0]      req_template_level = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [gsbm_pkg::CODE_W-1:0]       rsp_character_code;
   logic [gsbm_pkg::DISTANCE_W-1:0]   rsp_best_distance;

   // Shadow copies of the template store and the gray block buffer
   logic [7:0] glyph_levels [0:GLYPHS*BLOCK_PIXELS-1];
   logic [7:0] block_gray [0:BLOCK_PIXELS-1];

   glyph_match_type pending_matches [$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  beats_taken = 0;
   bit  quiet_tail = 1'b0;
   bit  req_bursty = 1'b0;
   int  req_phase_left = 0;
   bit  rsp_bursty = 1'b1;
   int  rsp_phase_left = 0;
   int  rsp_stall_left = 0;

   // Directed beats over an all-zero store with positions 0..30 held white
   script_row_type script [0:SCRIPT_ROWS-1] = '{
      '{PIXEL, 7'd0,   5'd31, 8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 7'd33,  13'd8160},
      '{PIXEL, 7'd0,   5'd31, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 7'd33,  13'd7905},
      '{LOAD,  7'd93,  5'd0,  8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd31, 8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 7'd126, 13'd7905},
      '{LOAD,  7'd50,  5'd7,  8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd31, 8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 7'd83,  13'd7905},
      '{LOAD,  7'd127, 5'd1,  8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 7'd0,   13'd0},
      '{LOAD,  7'd94,  5'd2,  8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd31, 8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 7'd83,  13'd7905},
      '{LOAD,  7'd0,   5'd31, 8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd31, 8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 7'd33,  13'd7905},
      '{PIXEL, 7'd0,   5'd31, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd31, 8'd0,   8'd255, 8'd0,   8'd0,   1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd31, 8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd31, 8'd1,   8'd1,   8'd1,   8'd0,   1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd127, 5'd0,  8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd127, 5'd31, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 7'd33,  13'd7650},
      '{LOAD,  7'd0,   5'd31, 8'd255, 8'd255, 8'd255, 8'd0,   1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd31, 8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 7'd83,  13'd7650},
      '{LOAD,  7'd93,  5'd31, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd0,  8'd255, 8'd255, 8'd255, 8'd0,   1'b0, 7'd0,   13'd0},
      '{PIXEL, 7'd0,   5'd31, 8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 7'd126, 13'd7650}
   };

   glyph_sad_best_match u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_glyph_slot     (req_glyph_slot),
      .req_pixel_position (req_pixel_position),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_template_level (req_template_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_character_code (rsp_character_code),
      .rsp_best_distance  (rsp_best_distance)
   );

   always #6 clock = ~clock;

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   function automatic glyph_req_type make_beat(input logic cmd, input int unsigned slot,
                                               input int unsigned pos, input int unsigned red,
                                               input int unsigned green, input int unsigned blue,
                                               input int unsigned level);
      glyph_req_type b;
      b.command = cmd;
      b.slot    = 7'(slot);
      b.pos     = 5'(pos);
      b.red     = 8'(red);
      b.green   = 8'(green);
      b.blue    = 8'(blue);
      b.level   = 8'(level);
      return b;
   endfunction

   function automatic glyph_req_type random_beat(input logic cmd, input int unsigned slot,
                                                 input int unsigned pos);
      return make_beat(cmd, slot, pos, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255));
   endfunction

   // Apply one beat to the shadow state; return 1 when it yields a match
   function automatic bit predict_match(input glyph_req_type b, output glyph_match_type m);
      int unsigned luma;
      int unsigned t;
      int unsigned v;
      int unsigned sum;
      int unsigned best_sum;
      int unsigned best_slot;
      int s;
      int p;
      m = '0;
      if (b.pos >= BLOCK_PIXELS) return 1'b0;
      if (b.command == LOAD) begin
         if (b.slot < GLYPHS) glyph_levels[b.slot*BLOCK_PIXELS + b.pos] = b.level;
         return 1'b0;
      end
      luma = (b.red * LUMA_R + b.green * LUMA_G + b.blue * LUMA_B) >> 16;
      block_gray[b.pos] = luma[7:0];
      if (b.pos != BLOCK_PIXELS - 1) return 1'b0;

      // Scan every glyph; strict less-than keeps the lowest slot on ties
      best_sum  = 32'hFFFF_FFFF;
      best_slot = 0;
      for (s = 0; s < GLYPHS; s++) begin
         sum = 0;
         for (p = 0; p < BLOCK_PIXELS; p++) begin
            t = glyph_levels[s*BLOCK_PIXELS + p];
            v = block_gray[p];
            sum += (t > v) ? t - v : v - t;
         end
         if (sum < best_sum) begin
            best_sum  = sum;
            best_slot = s;
         end
      end
      if (best_sum > DIST_CEIL) best_sum = DIST_CEIL;
      m.code     = 7'((CHAR_BASE + best_slot) & 32'h7F);
      m.distance = 13'(best_sum);
      return 1'b1;
   endfunction

   // Drive one request beat, hold it until taken, then predict its match
   task automatic send_beat(input glyph_req_type b, input bit typed = 1'b0,
                            input glyph_match_type want = '0);
      glyph_match_type predicted;
      if (req_phase_left == 0) begin
         req_bursty     = ~req_bursty;
         req_phase_left = $urandom_range(16, 160);
      end
      req_phase_left--;
      if (!quiet_tail && req_bursty && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= b.command;
      req_glyph_slot     <= b.slot;
      req_pixel_position <= b.pos;
      req_red            <= b.red;
      req_green          <= b.green;
      req_blue           <= b.blue;
      req_template_level <= b.level;
      do @(posedge clock); while (req_stall);
      if (predict_match(b, predicted)) begin
         if (typed) predicted = want;
         pending_matches.insert(pending_matches.size(), predicted);
      end
      if (!(b.command == LOAD && b.slot >= GLYPHS)) beats_taken++;
   endtask

   // Send pixels 0..last_pos of one block in raster order
   task automatic send_block(input block_fill_type fill, input int last_pos);
      int src;
      int p;
      int unsigned v;
      int unsigned r;
      int unsigned g;
      int unsigned bl;
      src = $urandom_range(0, GLYPHS - 1);
      r   = ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255);
      g   = $urandom_range(0, 255);
      bl  = $urandom_range(0, 255);
      for (p = 0; p <= last_pos; p++) begin
         v = glyph_levels[src*BLOCK_PIXELS + p];
         case (fill)
            FILL_UNIFORM:
               send_beat(make_beat(PIXEL, $urandom_range(0, 127), p, r, g, bl,
                                   $urandom_range(0, 255)));
            FILL_REPLICA:
               send_beat(make_beat(PIXEL, $urandom_range(0, 127), p, v, v, v,
                                   $urandom_range(0, 255)));
            FILL_NEAR:
               if ($urandom_range(0, 7) == 0)
                  send_beat(random_beat(PIXEL, $urandom_range(0, 127), p));
               else
                  send_beat(make_beat(PIXEL, $urandom_range(0, 127), p, v, v, v,
                                      $urandom_range(0, 255)));
            default:
               send_beat(random_beat(PIXEL, $urandom_range(0, 127), p));
         endcase
      end
   endtask

   // Result side: random stall bursts in bursty stretches, none in the tail
   always @(posedge clock) begin
      if (rsp_phase_left == 0) begin
         rsp_bursty     = ~rsp_bursty;
         rsp_phase_left = $urandom_range(300, 3000);
      end
      rsp_phase_left--;
      if (reset || quiet_tail) begin
         rsp_stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_bursty && $urandom_range(0, 7) == 0) begin
         rsp_stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result beat with the oldest pending match
   always @(posedge clock) begin : check_result
      glyph_match_type oldest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_matches.size() == 0) begin
            flag_mismatch("unexpected result beat, code", 0, rsp_character_code);
         end else begin
            oldest = pending_matches.pop_front();
            if (rsp_character_code !== oldest.code)
               flag_mismatch("character code", oldest.code, rsp_character_code);
            if (rsp_best_distance !== oldest.distance)
               flag_mismatch("best distance", oldest.distance, rsp_best_distance);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      glyph_match_type typed_match;
      int s;
      int p;
      int i;
      int a;
      int b;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Clear the whole template store and fill pixels 0..30 with white
      for (s = 0; s < GLYPHS; s++)
         for (p = 0; p < BLOCK_PIXELS; p++)
            send_beat(make_beat(LOAD, s, p, 0, 0, 0, 0));
      for (p = 0; p < BLOCK_PIXELS - 1; p++)
         send_beat(make_beat(PIXEL, 0, p, 255, 255, 255, 0));

      // Walk the directed table
      for (i = 0; i < SCRIPT_ROWS; i++) begin
         typed_match.code     = script[i].want_code;
         typed_match.distance = script[i].want_dist;
         send_beat(make_beat(script[i].cmd, script[i].slot, script[i].pos, script[i].red,
                             script[i].green, script[i].blue, script[i].level),
                   script[i].typed, typed_match);
      end

      // Reload every template with random levels
      for (s = 0; s < GLYPHS; s++)
         for (p = 0; p < BLOCK_PIXELS; p++)
            send_beat(random_beat(LOAD, s, p));

      // Random part: mostly whole blocks, with template edits and noise between
      beats_taken = 0;
      while (beats_taken < ITEMS_TARGET) begin
         quiet_tail = (beats_taken + 200 >= ITEMS_TARGET);
         case ($urandom_range(0, 9))
            0, 1:    send_block(FILL_RANDOM, BLOCK_PIXELS - 1);
            2:       send_block(FILL_UNIFORM, BLOCK_PIXELS - 1);
            3:       send_block(FILL_REPLICA, BLOCK_PIXELS - 1);
            4, 5:    send_block(FILL_NEAR, BLOCK_PIXELS - 1);
            6: begin
               repeat ($urandom_range(1, 8))
                  send_beat(random_beat(LOAD, $urandom_range(0, 127),
                                        $urandom_range(0, BLOCK_PIXELS - 1)));
            end
            7: begin
               // Copy one glyph over another to set up exact ties
               a = $urandom_range(0, GLYPHS - 1);
               b = $urandom_range(0, GLYPHS - 1);
               for (p = 0; p < BLOCK_PIXELS; p++)
                  send_beat(make_beat(LOAD, b, p, $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 255),
                                      glyph_levels[a*BLOCK_PIXELS + p]));
            end
            8:       send_beat(random_beat($urandom_range(0, 1), $urandom_range(0, 127),
                                           $urandom_range(0, BLOCK_PIXELS - 1)));
            default: send_block(block_fill_type'($urandom_range(0, 3)),
                                $urandom_range(0, BLOCK_PIXELS - 3));
         endcase
      end
      req_valid <= 1'b0;

      // Drain: wait for every pending match, then watch for strays
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
src/gsbm_pkg.sv
src/gsbm_ram.sv
src/gsbm_gray.sv
src/gsbm_sad.sv
src/glyph_sad_best_match.sv
bench/glyph_sad_best_match_tb.sv
